// ===== hdl/mctr_pkg.sv =====
`timescale 1ns / 1ps

package mctr_pkg;

  // sizing
  localparam int NUM_FILES  = 16;
  localparam int MAX_CHUNKS = 64;
  localparam int FID_W      = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
  localparam int IDX_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CQ_DEPTH   = 4;
  localparam int CQ_AW      = $clog2(CQ_DEPTH);

  typedef enum logic [1:0] {
    ACT_DEFINE = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_END    = 2'd2,
    ACT_OTHER  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_RETX   = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_DEFINED    = 4'd0,
    ST_STORED     = 4'd1,
    ST_BAD_FILE   = 4'd2,
    ST_UNTRACKED  = 4'd3,
    ST_BAD_SEQ    = 4'd4,
    ST_CORRUPT    = 4'd5,
    ST_DUPLICATE  = 4'd6,
    ST_DONE       = 4'd7,
    ST_TRACKING   = 4'd8,
    ST_INTEG_FAIL = 4'd9,
    ST_IGNORED    = 4'd10,
    ST_TOO_LARGE  = 4'd11
  } status_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TRACK = 2'd1,
    MODE_DONE  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    BK_CMD,
    BK_SECOND,
    BK_SCAN
  } back_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] file_id;
    logic [15:0] seq;
    logic [15:0] chunk_total;
    logic [31:0] file_sum;
    logic [31:0] chunk_checksum;
    logic [7:0]  data_byte;
    logic        byte_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  status;
    logic [15:0] out_file_id;
    logic [15:0] out_seq;
    logic        last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]       action;
    logic [15:0]      fid;
    logic             fid_ok;
    logic [15:0]      seq;
    logic             total_ok;
    logic [CNT_W-1:0] total;
    logic [31:0]      fsum;
    logic [31:0]      sum;
    logic             sum_ok;
  } cmd_t;

endpackage

// ===== hdl/mctr_front.sv =====
`timescale 1ns / 1ps

module mctr_front import mctr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output cmd_t     push_cmd_o
);

  logic [31:0] psum_q, psum_d;
  logic [31:0] sum;
  logic        accept;
  logic        mid_byte;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sum        = psum_q + {24'd0, in_item_i.data_byte};
  assign mid_byte   = (in_item_i.action == ACT_DATA) && !in_item_i.byte_last;

  // bytes before the last one of a packet only feed the running sum
  assign push_valid_o = in_valid_i && !mid_byte;

  // classify the beat
  always_comb begin
    push_cmd_o.action   = in_item_i.action;
    push_cmd_o.fid      = in_item_i.file_id;
    push_cmd_o.fid_ok   = in_item_i.file_id < 16'(NUM_FILES);
    push_cmd_o.seq      = in_item_i.seq;
    push_cmd_o.total_ok = in_item_i.chunk_total <= 16'(MAX_CHUNKS);
    push_cmd_o.total    = in_item_i.chunk_total[CNT_W-1:0];
    push_cmd_o.fsum     = in_item_i.file_sum;
    push_cmd_o.sum      = sum;
    push_cmd_o.sum_ok   = sum == in_item_i.chunk_checksum;
  end

  // packet byte sum, cleared on the last byte and on any non-byte beat
  always_comb begin
    psum_d = psum_q;
    if (accept) begin
      psum_d = mid_byte ? sum : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psum_q <= 32'd0;
    end else begin
      psum_q <= psum_d;
    end
  end

endmodule

// ===== hdl/mctr_cmd_fifo.sv =====
`timescale 1ns / 1ps

module mctr_cmd_fifo import mctr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t             mem_q [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_AW:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != (CQ_AW + 1)'(CQ_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + CQ_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + CQ_AW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + (CQ_AW + 1)'(1);
      2'b01:   count_d = count_q - (CQ_AW + 1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hdl/mctr_back.sv =====
`timescale 1ns / 1ps

module mctr_back import mctr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // per-slot tracking state
  mode_e             mode_q [NUM_FILES];
  logic [CNT_W-1:0]  exp_q  [NUM_FILES];
  logic [31:0]       esum_q [NUM_FILES];
  logic [CNT_W-1:0]  cnt_q  [NUM_FILES];
  logic [31:0]       rsum_q [NUM_FILES];
  logic [MAX_CHUNKS-1:0] map_q [NUM_FILES];

  back_state_e       state_q, state_d;
  logic [FID_W-1:0]  cur_idx_q;
  logic [15:0]       cur_fid_q;
  logic [15:0]       cur_seq_q;
  logic [CNT_W-1:0]  scan_j_q;
  logic              pend_v_q;
  logic [CNT_W-1:0]  pend_seq_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [FID_W-1:0]  rd_idx;
  mode_e             mode_rd;
  logic [CNT_W-1:0]  exp_rd, cnt_rd, cnt_inc;
  logic [31:0]       esum_rd, rsum_rd;
  logic [MAX_CHUNKS-1:0] map_rd;
  logic              is_track, is_done, sum_match;
  logic              out_free, at_end, miss, seq_bad, seq_dup;

  logic              pop, emit;
  out_item_t         res;
  logic              do_define, do_store, set_done;
  logic              go_second, go_scan, scan_step, pend_load, scan_end;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = pop;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // slot read, from the new command or the one in progress
  assign rd_idx    = (state_q == BK_CMD) ? cmd_i.fid[FID_W-1:0] : cur_idx_q;
  assign mode_rd   = mode_q[rd_idx];
  assign exp_rd    = exp_q[rd_idx];
  assign esum_rd   = esum_q[rd_idx];
  assign cnt_rd    = cnt_q[rd_idx];
  assign rsum_rd   = rsum_q[rd_idx];
  assign map_rd    = map_q[rd_idx];
  assign is_track  = mode_rd == MODE_TRACK;
  assign is_done   = mode_rd == MODE_DONE;
  assign sum_match = rsum_rd == esum_rd;
  assign cnt_inc   = cnt_rd + CNT_W'(1);
  assign seq_bad   = cmd_i.seq >= 16'(exp_rd);
  assign seq_dup   = map_rd[cmd_i.seq[IDX_W-1:0]];
  assign at_end    = scan_j_q >= exp_rd;
  assign miss      = !map_rd[scan_j_q[IDX_W-1:0]];

  // command decode and result selection
  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    res       = '0;
    do_define = 1'b0;
    do_store  = 1'b0;
    set_done  = 1'b0;
    go_second = 1'b0;
    go_scan   = 1'b0;
    scan_step = 1'b0;
    pend_load = 1'b0;
    scan_end  = 1'b0;
    unique case (state_q)
      BK_CMD: begin
        if (cmd_valid_i && out_free) begin
          pop             = 1'b1;
          emit            = 1'b1;
          res.kind        = KIND_STATUS;
          res.out_file_id = cmd_i.fid;
          res.last        = 1'b1;
          unique case (cmd_i.action)
            ACT_DATA: begin
              res.out_seq = cmd_i.seq;
              if (!cmd_i.fid_ok) begin
                res.status = ST_BAD_FILE;
              end else if (!is_track && !is_done) begin
                res.status = ST_UNTRACKED;
              end else if (is_done) begin
                res.status = ST_DONE;
              end else if (seq_bad) begin
                res.status = ST_BAD_SEQ;
              end else if (!cmd_i.sum_ok) begin
                res.status = ST_CORRUPT;
              end else if (seq_dup) begin
                res.status = ST_DUPLICATE;
              end else begin
                do_store   = 1'b1;
                res.status = ST_STORED;
                if (cnt_inc == exp_rd) begin
                  res.last  = 1'b0;
                  go_second = 1'b1;
                end
              end
            end
            ACT_OTHER: begin
              res.status = ST_IGNORED;
            end
            ACT_DEFINE: begin
              if (!cmd_i.fid_ok) begin
                res.status = ST_BAD_FILE;
              end else if (is_done) begin
                res.status = ST_DONE;
              end else if (is_track) begin
                res.status = ST_TRACKING;
              end else if (!cmd_i.total_ok) begin
                res.status = ST_TOO_LARGE;
              end else begin
                do_define  = 1'b1;
                res.status = ST_DEFINED;
              end
            end
            ACT_END: begin
              if (!cmd_i.fid_ok) begin
                res.status = ST_BAD_FILE;
              end else if (is_done) begin
                res.status = ST_DONE;
              end else if (!is_track) begin
                res.status = ST_UNTRACKED;
              end else if (sum_match) begin
                set_done   = 1'b1;
                res.kind   = KIND_DONE;
                res.status = ST_DONE;
              end else begin
                emit    = 1'b0;
                go_scan = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      // file check after the chunk that completed the count
      BK_SECOND: begin
        if (out_free) begin
          emit            = 1'b1;
          res.out_file_id = cur_fid_q;
          res.out_seq     = cur_seq_q;
          res.last        = 1'b1;
          res.status      = ST_INTEG_FAIL;
          res.kind        = KIND_STATUS;
          if (sum_match) begin
            set_done   = 1'b1;
            res.kind   = KIND_DONE;
            res.status = ST_DONE;
          end
        end
      end
      // walk the chunk map, one missing seq held back to tag the final one
      BK_SCAN: begin
        res.out_file_id = cur_fid_q;
        res.status      = ST_INTEG_FAIL;
        if (at_end) begin
          if (out_free) begin
            emit     = 1'b1;
            scan_end = 1'b1;
            res.last = 1'b1;
            if (pend_v_q) begin
              res.kind    = KIND_RETX;
              res.out_seq = 16'(pend_seq_q);
            end else begin
              res.kind = KIND_STATUS;
            end
          end
        end else if (miss) begin
          if (!pend_v_q) begin
            pend_load = 1'b1;
            scan_step = 1'b1;
          end else if (out_free) begin
            emit        = 1'b1;
            res.kind    = KIND_RETX;
            res.out_seq = 16'(pend_seq_q);
            pend_load   = 1'b1;
            scan_step   = 1'b1;
          end
        end else begin
          scan_step = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CMD: begin
        if (go_second) begin
          state_d = BK_SECOND;
        end else if (go_scan) begin
          state_d = BK_SCAN;
        end
      end
      BK_SECOND: begin
        if (out_free) begin
          state_d = BK_CMD;
        end
      end
      BK_SCAN: begin
        if (scan_end) begin
          state_d = BK_CMD;
        end
      end
      default: state_d = BK_CMD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CMD;
      cur_idx_q   <= '0;
      cur_fid_q   <= '0;
      cur_seq_q   <= '0;
      scan_j_q    <= '0;
      pend_v_q    <= 1'b0;
      pend_seq_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        cur_idx_q <= cmd_i.fid[FID_W-1:0];
        cur_fid_q <= cmd_i.fid;
        cur_seq_q <= cmd_i.seq;
      end
      if (go_scan) begin
        scan_j_q <= '0;
        pend_v_q <= 1'b0;
      end else if (scan_step) begin
        scan_j_q <= scan_j_q + CNT_W'(1);
      end
      if (pend_load) begin
        pend_v_q   <= 1'b1;
        pend_seq_q <= scan_j_q;
      end
      if (scan_end) begin
        pend_v_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  // slot state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FILES; i++) begin
        mode_q[i] <= MODE_IDLE;
        exp_q[i]  <= '0;
        esum_q[i] <= '0;
        cnt_q[i]  <= '0;
        rsum_q[i] <= '0;
        map_q[i]  <= '0;
      end
    end else begin
      if (do_define) begin
        mode_q[rd_idx] <= MODE_TRACK;
        exp_q[rd_idx]  <= cmd_i.total;
        esum_q[rd_idx] <= cmd_i.fsum;
        cnt_q[rd_idx]  <= '0;
        rsum_q[rd_idx] <= '0;
        map_q[rd_idx]  <= '0;
      end
      if (do_store) begin
        map_q[rd_idx][cmd_i.seq[IDX_W-1:0]] <= 1'b1;
        cnt_q[rd_idx]  <= cnt_inc;
        rsum_q[rd_idx] <= rsum_rd + cmd_i.sum;
      end
      if (set_done) begin
        mode_q[rd_idx] <= MODE_DONE;
      end
    end
  end

  // the map walk never passes the chunk count
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SCAN |-> scan_j_q <= exp_rd)
    else $error("chunk map walk ran past the chunk count");

  // a held-back request only lives during a walk
  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> state_q == BK_SCAN)
    else $error("pending request outside the map walk");

  // the completion check follows a chunk that filled the count
  a_second_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SECOND |-> cnt_rd == exp_rd)
    else $error("completion check without a full chunk count");

  // the final result of a command frees the back end
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res.last) |=> state_q == BK_CMD)
    else $error("back end busy after final result");

  // nothing is loaded over a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !emit)
    else $error("result register overwritten while stalled");

endmodule

// ===== hdl/multicast_chunk_reassembly_tracker_top.sv =====
`timescale 1ns / 1ps

// Chunked multicast file reassembly tracker for up to NUM_FILES slots.
// Input channel (in_valid_i/in_ready_o, in_item_i): define, data byte, end
// and other beats. Data bytes come one per beat; only the last byte of a
// packet produces results. Output channel (out_valid_o/out_ready_i,
// out_item_o): status, retransmit request and complete notice beats, with
// last set on the final result of each input beat.
// Data bytes other than the last only feed the packet sum and are taken
// whenever the queue has room. Every other beat is queued (four entries) for
// the back end, which handles one command at a time; its results go out
// through the result register, and a chunk that completes a file is followed
// by a file check with its own result. An end beat with a file sum
// mismatch walks the chunk map one seq per cycle, pausing while a held-back
// request waits on a stalled receiver; its final result ends the walk.
// Reset clears every slot to idle and empties the queue and packet sum.
// When the receiver stalls, the result register holds, the back end waits,
// and once the queue fills in_ready_o drops.
module multicast_chunk_reassembly_tracker_top import mctr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  mctr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  mctr_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  mctr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
